[src/rvr_pkg.sv]
// ----------------------------------------------------------------------------
// rvr_pkg
// Shared widths and pipeline payload types for the rotor rotation unit.
// ----------------------------------------------------------------------------
package rvr_pkg;

   // field formats: rotor parts signed Q2.16, point coordinates signed Q16.16
   localparam int C_ROTOR_W = 18;
   localparam int C_POINT_W = 32;
   localparam int C_FRAC    = 16;

   // intermediate widths, each just wide enough for its full range
   localparam int C_BP_W  = 50;  // bivector part * coordinate
   localparam int C_SS_W  = 36;  // scalar squared, 32 fraction bits
   localparam int C_M_W   = 35;  // m components, 16 fraction bits
   localparam int C_DOT_W = 36;  // dot term, 16 fraction bits
   localparam int C_S2_W  = 20;  // rounded scalar squared
   localparam int C_S2P_W = 52;  // s2 * coordinate
   localparam int C_SM_W  = 53;  // scalar * m
   localparam int C_BM_W  = 53;  // bivector part * m
   localparam int C_BD_W  = 54;  // bivector part * dot
   localparam int C_ACC_W = 56;  // final sum, 32 fraction bits
   localparam int C_RND_W = 40;  // final sum rounded to 16 fraction bits

   localparam logic signed [C_POINT_W-1:0] C_POS_MAX = {1'b0, {(C_POINT_W-1){1'b1}}};
   localparam logic signed [C_POINT_W-1:0] C_NEG_MIN = {1'b1, {(C_POINT_W-1){1'b0}}};

   typedef struct packed {
      logic signed [C_ROTOR_W-1:0] s;
      logic signed [C_ROTOR_W-1:0] b12;
      logic signed [C_ROTOR_W-1:0] b23;
      logic signed [C_ROTOR_W-1:0] b31;
      logic signed [C_POINT_W-1:0] px;
      logic signed [C_POINT_W-1:0] py;
      logic signed [C_POINT_W-1:0] pz;
   } rvr_item_type;

   typedef struct packed {
      logic signed [C_BP_W-1:0] b12py;
      logic signed [C_BP_W-1:0] b31pz;
      logic signed [C_BP_W-1:0] b23pz;
      logic signed [C_BP_W-1:0] b12px;
      logic signed [C_BP_W-1:0] b31px;
      logic signed [C_BP_W-1:0] b23py;
      logic signed [C_BP_W-1:0] b12pz;
      logic signed [C_BP_W-1:0] b23px;
      logic signed [C_BP_W-1:0] b31py;
      logic signed [C_SS_W-1:0] ss;
      rvr_item_type             item;
   } rvr_prod_type;

   typedef struct packed {
      logic signed [C_M_W-1:0]     mx;
      logic signed [C_M_W-1:0]     my;
      logic signed [C_M_W-1:0]     mz;
      logic signed [C_DOT_W-1:0]   dt;
      logic signed [C_S2_W-1:0]    s2;
      logic signed [C_ROTOR_W-1:0] s;
      logic signed [C_ROTOR_W-1:0] b12;
      logic signed [C_ROTOR_W-1:0] b23;
      logic signed [C_ROTOR_W-1:0] b31;
      logic signed [C_POINT_W-1:0] px;
      logic signed [C_POINT_W-1:0] py;
      logic signed [C_POINT_W-1:0] pz;
   } rvr_mix_type;

   typedef struct packed {
      logic signed [C_S2P_W-1:0] s2px;
      logic signed [C_S2P_W-1:0] s2py;
      logic signed [C_S2P_W-1:0] s2pz;
      logic signed [C_SM_W-1:0]  smx;
      logic signed [C_SM_W-1:0]  smy;
      logic signed [C_SM_W-1:0]  smz;
      logic signed [C_BM_W-1:0]  b31mz;
      logic signed [C_BM_W-1:0]  b12my;
      logic signed [C_BM_W-1:0]  b12mx;
      logic signed [C_BM_W-1:0]  b23mz;
      logic signed [C_BM_W-1:0]  b23my;
      logic signed [C_BM_W-1:0]  b31mx;
      logic signed [C_BD_W-1:0]  b23dt;
      logic signed [C_BD_W-1:0]  b31dt;
      logic signed [C_BD_W-1:0]  b12dt;
   } rvr_term_type;

   typedef struct packed {
      logic signed [C_RND_W-1:0] rx;
      logic signed [C_RND_W-1:0] ry;
      logic signed [C_RND_W-1:0] rz;
   } rvr_rnd_type;

   typedef struct packed {
      logic signed [C_POINT_W-1:0] rotated_x;
      logic signed [C_POINT_W-1:0] rotated_y;
      logic signed [C_POINT_W-1:0] rotated_z;
      logic                        overflow;
   } rvr_out_type;

endpackage

[src/rvr_req_if.sv]
// ----------------------------------------------------------------------------
// rvr_req_if
// Request channel: rotor and point, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rvr_req_if import rvr_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [C_ROTOR_W-1:0] rotor_scalar;
   logic signed [C_ROTOR_W-1:0] rotor_e12;
   logic signed [C_ROTOR_W-1:0] rotor_e23;
   logic signed [C_ROTOR_W-1:0] rotor_e31;
   logic signed [C_POINT_W-1:0] point_x;
   logic signed [C_POINT_W-1:0] point_y;
   logic signed [C_POINT_W-1:0] point_z;

   modport source (
      output valid, rotor_scalar, rotor_e12, rotor_e23, rotor_e31,
             point_x, point_y, point_z,
      input  ready
   );
   modport sink (
      input  valid, rotor_scalar, rotor_e12, rotor_e23, rotor_e31,
             point_x, point_y, point_z,
      output ready
   );
endinterface

[src/rvr_rsp_if.sv]
// ----------------------------------------------------------------------------
// rvr_rsp_if
// Response channel: rotated point and overflow flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rvr_rsp_if import rvr_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [C_POINT_W-1:0] rotated_x;
   logic signed [C_POINT_W-1:0] rotated_y;
   logic signed [C_POINT_W-1:0] rotated_z;
   logic                        overflow;

   modport source (
      output valid, rotated_x, rotated_y, rotated_z, overflow,
      input  ready
   );
   modport sink (
      input  valid, rotated_x, rotated_y, rotated_z, overflow,
      output ready
   );
endinterface

[src/rvr_cross.sv]
// ----------------------------------------------------------------------------
// rvr_cross
// Stages 1-2: bivector-by-point products and scalar square, then the
// rounded m vector, dot term and s^2.
// ----------------------------------------------------------------------------
module rvr_cross import rvr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rvr_item_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output rvr_mix_type  out_data,
   output logic [1:0]   stage_valid
);

   localparam int SUM_M_W   = C_BP_W + 1;
   localparam int SUM_DOT_W = C_DOT_W + C_FRAC;
   localparam logic signed [SUM_M_W-1:0]   HALF_M   = SUM_M_W'(1 << (C_FRAC - 1));
   localparam logic signed [SUM_DOT_W-1:0] HALF_DOT = SUM_DOT_W'(1 << (C_FRAC - 1));
   localparam logic signed [C_SS_W-1:0]    HALF_SS  = C_SS_W'(1 << (C_FRAC - 1));

   logic         a_valid_ff;
   logic         a_ready;
   rvr_prod_type a_data_ff;
   rvr_prod_type a_data_in;
   logic         b_valid_ff;
   logic         b_ready;
   rvr_mix_type  b_data_ff;
   rvr_mix_type  b_data_in;

   logic signed [SUM_M_W-1:0]   mx_sum;
   logic signed [SUM_M_W-1:0]   my_sum;
   logic signed [SUM_M_W-1:0]   mz_sum;
   logic signed [SUM_DOT_W-1:0] dot_sum;
   logic signed [C_SS_W-1:0]    ss_sum;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // stage 1: products
   always_comb begin
      a_data_in       = '0;
      a_data_in.item  = in_data;
      a_data_in.b12py = in_data.b12 * in_data.py;
      a_data_in.b31pz = in_data.b31 * in_data.pz;
      a_data_in.b23pz = in_data.b23 * in_data.pz;
      a_data_in.b12px = in_data.b12 * in_data.px;
      a_data_in.b31px = in_data.b31 * in_data.px;
      a_data_in.b23py = in_data.b23 * in_data.py;
      a_data_in.b12pz = in_data.b12 * in_data.pz;
      a_data_in.b23px = in_data.b23 * in_data.px;
      a_data_in.b31py = in_data.b31 * in_data.py;
      a_data_in.ss    = in_data.s * in_data.s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         a_data_ff <= a_data_in;
      end
   end

   // stage 2: combine and round to 16 fraction bits
   always_comb begin
      mx_sum  = SUM_M_W'(a_data_ff.b12py) - SUM_M_W'(a_data_ff.b31pz) + HALF_M;
      my_sum  = SUM_M_W'(a_data_ff.b23pz) - SUM_M_W'(a_data_ff.b12px) + HALF_M;
      mz_sum  = SUM_M_W'(a_data_ff.b31px) - SUM_M_W'(a_data_ff.b23py) + HALF_M;
      dot_sum = SUM_DOT_W'(a_data_ff.b12pz) + SUM_DOT_W'(a_data_ff.b23px)
              + SUM_DOT_W'(a_data_ff.b31py) + HALF_DOT;
      ss_sum  = a_data_ff.ss + HALF_SS;

      b_data_in     = '0;
      b_data_in.mx  = mx_sum[SUM_M_W-1:C_FRAC];
      b_data_in.my  = my_sum[SUM_M_W-1:C_FRAC];
      b_data_in.mz  = mz_sum[SUM_M_W-1:C_FRAC];
      b_data_in.dt  = dot_sum[SUM_DOT_W-1:C_FRAC];
      b_data_in.s2  = ss_sum[C_SS_W-1:C_FRAC];
      b_data_in.s   = a_data_ff.item.s;
      b_data_in.b12 = a_data_ff.item.b12;
      b_data_in.b23 = a_data_ff.item.b23;
      b_data_in.b31 = a_data_ff.item.b31;
      b_data_in.px  = a_data_ff.item.px;
      b_data_in.py  = a_data_ff.item.py;
      b_data_in.pz  = a_data_ff.item.pz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid   = b_valid_ff;
   assign out_data    = b_data_ff;
   assign stage_valid = {b_valid_ff, a_valid_ff};

endmodule

[src/rvr_sandwich.sv]
// ----------------------------------------------------------------------------
// rvr_sandwich
// Stages 3-4: second round of products, then the five-term sum per axis
// rounded to 16 fraction bits.
// ----------------------------------------------------------------------------
module rvr_sandwich import rvr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rvr_mix_type  in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output rvr_rnd_type  out_data,
   output logic [1:0]   stage_valid
);

   localparam logic signed [C_ACC_W-1:0] HALF_ACC = C_ACC_W'(1 << (C_FRAC - 1));

   logic         c_valid_ff;
   logic         c_ready;
   rvr_term_type c_data_ff;
   rvr_term_type c_data_in;
   logic         d_valid_ff;
   logic         d_ready;
   rvr_rnd_type  d_data_ff;
   rvr_rnd_type  d_data_in;

   logic signed [C_ACC_W-1:0] acc_x;
   logic signed [C_ACC_W-1:0] acc_y;
   logic signed [C_ACC_W-1:0] acc_z;

   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   // stage 3: products, all with 32 fraction bits
   always_comb begin
      c_data_in       = '0;
      c_data_in.s2px  = in_data.s2 * in_data.px;
      c_data_in.s2py  = in_data.s2 * in_data.py;
      c_data_in.s2pz  = in_data.s2 * in_data.pz;
      c_data_in.smx   = in_data.s * in_data.mx;
      c_data_in.smy   = in_data.s * in_data.my;
      c_data_in.smz   = in_data.s * in_data.mz;
      c_data_in.b31mz = in_data.b31 * in_data.mz;
      c_data_in.b12my = in_data.b12 * in_data.my;
      c_data_in.b12mx = in_data.b12 * in_data.mx;
      c_data_in.b23mz = in_data.b23 * in_data.mz;
      c_data_in.b23my = in_data.b23 * in_data.my;
      c_data_in.b31mx = in_data.b31 * in_data.mx;
      c_data_in.b23dt = in_data.b23 * in_data.dt;
      c_data_in.b31dt = in_data.b31 * in_data.dt;
      c_data_in.b12dt = in_data.b12 * in_data.dt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= in_valid;
      end
      if (c_ready && in_valid) begin
         c_data_ff <= c_data_in;
      end
   end

   // stage 4: s2 p + 2 s m - (m B) + (b23, b31, b12) dt, plus half an LSB for rounding
   always_comb begin
      acc_x = C_ACC_W'(c_data_ff.s2px) + (C_ACC_W'(c_data_ff.smx) <<< 1)
            - C_ACC_W'(c_data_ff.b31mz) + C_ACC_W'(c_data_ff.b12my)
            + C_ACC_W'(c_data_ff.b23dt) + HALF_ACC;
      acc_y = C_ACC_W'(c_data_ff.s2py) + (C_ACC_W'(c_data_ff.smy) <<< 1)
            - C_ACC_W'(c_data_ff.b12mx) + C_ACC_W'(c_data_ff.b23mz)
            + C_ACC_W'(c_data_ff.b31dt) + HALF_ACC;
      acc_z = C_ACC_W'(c_data_ff.s2pz) + (C_ACC_W'(c_data_ff.smz) <<< 1)
            - C_ACC_W'(c_data_ff.b23my) + C_ACC_W'(c_data_ff.b31mx)
            + C_ACC_W'(c_data_ff.b12dt) + HALF_ACC;

      d_data_in.rx = acc_x[C_ACC_W-1:C_FRAC];
      d_data_in.ry = acc_y[C_ACC_W-1:C_FRAC];
      d_data_in.rz = acc_z[C_ACC_W-1:C_FRAC];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_ready) begin
         d_valid_ff <= c_valid_ff;
      end
      if (d_ready && c_valid_ff) begin
         d_data_ff <= d_data_in;
      end
   end

   assign out_valid   = d_valid_ff;
   assign out_data    = d_data_ff;
   assign stage_valid = {d_valid_ff, c_valid_ff};

endmodule

[src/rvr_saturate.sv]
// ----------------------------------------------------------------------------
// rvr_saturate
// Stage 5: clamp each coordinate to Q16.16, flag overflow, hold the result
// in the output register.
// ----------------------------------------------------------------------------
module rvr_saturate import rvr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  rvr_rnd_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output rvr_out_type out_data
);

   logic        o_valid_ff;
   rvr_out_type o_data_ff;
   rvr_out_type o_data_in;
   logic [2:0]  clip;

   // return {clipped, value}
   function automatic logic [C_POINT_W:0] clamp(input logic signed [C_RND_W-1:0] v);
      logic [C_RND_W-C_POINT_W:0] top;
      logic [C_POINT_W:0]         res;
      top = v[C_RND_W-1:C_POINT_W-1];
      if ((&top) || !(|top)) begin
         res = {1'b0, v[C_POINT_W-1:0]};
      end else if (v[C_RND_W-1]) begin
         res = {1'b1, C_NEG_MIN};
      end else begin
         res = {1'b1, C_POS_MAX};
      end
      return res;
   endfunction

   always_comb begin
      {clip[0], o_data_in.rotated_x} = clamp(in_data.rx);
      {clip[1], o_data_in.rotated_y} = clamp(in_data.ry);
      {clip[2], o_data_in.rotated_z} = clamp(in_data.rz);
      o_data_in.overflow = |clip;
   end

   assign in_ready = !o_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (in_ready) begin
         o_valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         o_data_ff <= o_data_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_data  = o_data_ff;

endmodule

[src/rotate_vector_by_rotor_unit.sv]
// ----------------------------------------------------------------------------
// rotate_vector_by_rotor_unit
// Rotates a Q16.16 point by an unnormalized Q2.16 rotor, R p ~R, with
// round-half-up at each rescale and saturation of the result.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake          payload
//   req_ch    in          valid / ready      rotor_scalar, rotor_e12/e23/e31,
//                                            point_x/y/z
//   rsp_ch    out         valid / ready      rotated_x/y/z, overflow
//
// One transaction is taken per clock cycle in steady state, unless rsp_ch
// stalls. A result passes each stage register in turn up to the output
// register: two multiplier stages each followed by an adder/rounding stage,
// then a clamp stage. Reset (synchronous, active high) empties all five stages.
// When rsp_ch is stalled, each stage holds its data; req_ch.ready falls only
// once every stage is full, and an empty stage always lets the next one in.
//
module rotate_vector_by_rotor_unit import rvr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rvr_req_if.sink     req_ch,
   rvr_rsp_if.source   rsp_ch
);

   rvr_item_type req_item;
   rvr_mix_type  mix_data;
   rvr_rnd_type  rnd_data;
   rvr_out_type  out_data;

   logic       mix_valid;
   logic       mix_ready;
   logic       rnd_valid;
   logic       rnd_ready;
   logic [1:0] cross_stages;
   logic [1:0] sandwich_stages;
   logic [4:0] stage_valid;

   // transactions in flight, tracked from the ports for checking
   logic [2:0] occ_ff;
   logic [2:0] occ_in;

   // gather the request fields into one pipeline word
   always_comb begin
      req_item.s   = req_ch.rotor_scalar;
      req_item.b12 = req_ch.rotor_e12;
      req_item.b23 = req_ch.rotor_e23;
      req_item.b31 = req_ch.rotor_e31;
      req_item.px  = req_ch.point_x;
      req_item.py  = req_ch.point_y;
      req_item.pz  = req_ch.point_z;
   end

   // stages 1-2: B p products, m vector, dot term, s^2
   rvr_cross u_cross (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .in_data     (req_item),
      .out_valid   (mix_valid),
      .out_ready   (mix_ready),
      .out_data    (mix_data),
      .stage_valid (cross_stages)
   );

   // stages 3-4: second products and the rounded sum per axis
   rvr_sandwich u_sandwich (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mix_valid),
      .in_ready    (mix_ready),
      .in_data     (mix_data),
      .out_valid   (rnd_valid),
      .out_ready   (rnd_ready),
      .out_data    (rnd_data),
      .stage_valid (sandwich_stages)
   );

   // stage 5: clamp and hold for the response channel
   rvr_saturate u_saturate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rnd_valid),
      .in_ready  (rnd_ready),
      .in_data   (rnd_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   assign rsp_ch.rotated_x = out_data.rotated_x;
   assign rsp_ch.rotated_y = out_data.rotated_y;
   assign rsp_ch.rotated_z = out_data.rotated_z;
   assign rsp_ch.overflow  = out_data.overflow;

   assign stage_valid = {rsp_ch.valid, sandwich_stages, cross_stages};

   // count up on an accepted request, down on a delivered response
   always_comb begin
      occ_in = occ_ff;
      if (req_ch.valid && req_ch.ready) begin
         occ_in = occ_in + 3'd1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
         occ_in = occ_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 3'd0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // every accepted transaction sits in exactly one stage until delivered
   a_occupancy : assert property (@(posedge clock) disable iff (reset)
      $countones(stage_valid) == 32'(occ_ff))
      else $error("pipeline occupancy does not match transactions in flight");

   // a full pipeline with a stalled output must refuse new requests
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (&stage_valid) && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request accepted while pipeline full and stalled");

   // a flagged result carries at least one clamped coordinate
   a_overflow_clamped : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.overflow |->
         (rsp_ch.rotated_x == C_POS_MAX || rsp_ch.rotated_x == C_NEG_MIN ||
          rsp_ch.rotated_y == C_POS_MAX || rsp_ch.rotated_y == C_NEG_MIN ||
          rsp_ch.rotated_z == C_POS_MAX || rsp_ch.rotated_z == C_NEG_MIN))
      else $error("overflow flagged without a clamped coordinate");

   // reset empties the output stage
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");

endmodule

[sim/rotate_vector_by_rotor_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotate_vector_by_rotor_unit_tb
// Self-checking bench for the rotor rotation unit. A behavioral model of the
// sandwich product predicts every rotated point. A monitor compares each
// response transaction with the oldest prediction while both channels stall
// at random.
// ----------------------------------------------------------------------------
module rotate_vector_by_rotor_unit_tb;
   import rvr_pkg::*;

   localparam int ONE       = 1 << C_FRAC;   // 1.0 in both Q formats
   localparam int COS45     = 46341;         // cos(pi/4) in Q2.16
   localparam int ROTOR_MAX = 131071;
   localparam int ROTOR_MIN = -131072;
   localparam int POINT_MAX = 32'h7FFF_FFFF;
   localparam int POINT_MIN = 32'h8000_0000;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rvr_req_if req_ch ();
   rvr_rsp_if rsp_ch ();

   rotate_vector_by_rotor_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predicted points, oldest first
   rvr_out_type expected_points[$];
   rvr_out_type want;
   int          error_count    = 0;
   int          sent_count     = 0;
   int          checked_count  = 0;
   int          overflow_count = 0;
   int          cycle_count    = 0;
   // when set, neither side idles
   bit          steady_flow    = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // ------------------------------------------------------------------------
   // Behavioral model: round half up at every rescale, clamp at the end.
   // All intermediates fit comfortably in 64 bits.
   // ------------------------------------------------------------------------
   function automatic longint round_q16(input longint v);
      return (v + 64'sd32768) >>> C_FRAC;
   endfunction

   function automatic rvr_out_type rotate_point(input rvr_item_type it);
      longint s, b12, b23, b31, px, py, pz;
      longint mx, my, mz, dt, s2, two_s;
      longint sum [3];
      longint r;
      rvr_out_type res;
      logic [C_POINT_W-1:0] coord [3];
      s   = $signed(it.s);
      b12 = $signed(it.b12);
      b23 = $signed(it.b23);
      b31 = $signed(it.b31);
      px  = $signed(it.px);
      py  = $signed(it.py);
      pz  = $signed(it.pz);

      // vector part of B p
      mx = round_q16(b12 * py - b31 * pz);
      my = round_q16(b23 * pz - b12 * px);
      mz = round_q16(b31 * px - b23 * py);
      dt = round_q16(b12 * pz + b23 * px + b31 * py);
      s2 = round_q16(s * s);
      two_s = 2 * s;

      // s2 p + 2 s m - (m B) + (e23, e31, e12) dot
      sum[0] = s2 * px + two_s * mx - (b31 * mz - b12 * my) + b23 * dt;
      sum[1] = s2 * py + two_s * my - (b12 * mx - b23 * mz) + b31 * dt;
      sum[2] = s2 * pz + two_s * mz - (b23 * my - b31 * mx) + b12 * dt;

      res.overflow = 1'b0;
      for (int i = 0; i < 3; i++) begin
         r = round_q16(sum[i]);
         if (r > 64'sd2147483647) begin
            r = 64'sd2147483647;
            res.overflow = 1'b1;
         end else if (r < -64'sd2147483648) begin
            r = -64'sd2147483648;
            res.overflow = 1'b1;
         end
         coord[i] = r[C_POINT_W-1:0];
      end
      res.rotated_x = coord[0];
      res.rotated_y = coord[1];
      res.rotated_z = coord[2];
      return res;
   endfunction

   function automatic rvr_item_type make_item(input int s, input int b12, input int b23,
                                              input int b31, input int px, input int py,
                                              input int pz);
      rvr_item_type it;
      it.s   = s[C_ROTOR_W-1:0];
      it.b12 = b12[C_ROTOR_W-1:0];
      it.b23 = b23[C_ROTOR_W-1:0];
      it.b31 = b31[C_ROTOR_W-1:0];
      it.px  = px;
      it.py  = py;
      it.pz  = pz;
      return it;
   endfunction

   function automatic int any_rotor_part();
      return int'($urandom_range(0, 262143)) + ROTOR_MIN;
   endfunction

   // Mix of field shapes: wild rotors on small points, rotors with parts within
   // +/-37837 on any point, and raw bits everywhere.
   function automatic rvr_item_type random_rotation();
      int unsigned pick;
      int part [4];
      pick = $urandom_range(99);
      if (pick < 35) begin
         foreach (part[i]) part[i] = any_rotor_part();
         return make_item(part[0], part[1], part[2], part[3],
                          int'($urandom_range(0, 2097151)) - 1048576,
                          int'($urandom_range(0, 2097151)) - 1048576,
                          int'($urandom_range(0, 2097151)) - 1048576);
      end else if (pick < 70) begin
         foreach (part[i]) part[i] = int'($urandom_range(0, 75674)) - 37837;
         return make_item(part[0], part[1], part[2], part[3],
                          $urandom, $urandom, $urandom);
      end
      foreach (part[i]) part[i] = any_rotor_part();
      return make_item(part[0], part[1], part[2], part[3], $urandom, $urandom, $urandom);
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   task automatic send_rotation(input rvr_item_type it);
      // idle now and then, on any phase of the pipeline
      while (!steady_flow && $urandom_range(99) < 19) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.rotor_scalar <= it.s;
      req_ch.rotor_e12    <= it.b12;
      req_ch.rotor_e23    <= it.b23;
      req_ch.rotor_e31    <= it.b31;
      req_ch.point_x      <= it.px;
      req_ch.point_y      <= it.py;
      req_ch.point_z      <= it.pz;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_points.push_back(rotate_point(it));
      sent_count++;
   endtask

   // drop valid and let the clock tick so the next send starts clean
   task automatic drop_request();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Response side: random back-pressure plus checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ch.ready <= steady_flow || ($urandom_range(99) >= 19);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_points.size() == 0) begin
            error_count++;
            $error("response transaction with nothing outstanding: x=%0d y=%0d z=%0d",
                   rsp_ch.rotated_x, rsp_ch.rotated_y, rsp_ch.rotated_z);
         end else begin
            want = expected_points.pop_front();
            checked_count++;
            if (want.overflow) overflow_count++;
            if (rsp_ch.rotated_x !== want.rotated_x) begin
               error_count++;
               $error("rotated_x: expected %0d, got %0d", want.rotated_x, rsp_ch.rotated_x);
            end
            if (rsp_ch.rotated_y !== want.rotated_y) begin
               error_count++;
               $error("rotated_y: expected %0d, got %0d", want.rotated_y, rsp_ch.rotated_y);
            end
            if (rsp_ch.rotated_z !== want.rotated_z) begin
               error_count++;
               $error("rotated_z: expected %0d, got %0d", want.rotated_z, rsp_ch.rotated_z);
            end
            if (rsp_ch.overflow !== want.overflow) begin
               error_count++;
               $error("overflow: expected %0d, got %0d", want.overflow, rsp_ch.overflow);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // unit rotor leaves the point alone, even at the coordinate limits
   task automatic test_identity_rotor();
      send_rotation(make_item(ONE, 0, 0, 0, ONE, -2 * ONE, 3 * ONE + ONE / 2));
      send_rotation(make_item(ONE, 0, 0, 0, POINT_MAX, POINT_MIN, 0));
      send_rotation(make_item(ONE, 0, 0, 0, POINT_MIN, POINT_MAX, -1));
   endtask

   // quarter turns in each bivector plane, half turns in the e12 and e23 planes
   task automatic test_axis_turns();
      send_rotation(make_item(COS45, COS45, 0, 0, ONE, 2 * ONE, 3 * ONE));
      send_rotation(make_item(COS45, 0, COS45, 0, ONE, 2 * ONE, 3 * ONE));
      send_rotation(make_item(COS45, 0, 0, COS45, ONE, 2 * ONE, 3 * ONE));
      send_rotation(make_item(0, ONE, 0, 0, -5 * ONE, 7, ONE));
      send_rotation(make_item(0, 0, -ONE, 0, -5 * ONE, 7, ONE));
      send_rotation(make_item(-COS45, 0, 0, -COS45, 12345, -54321, 99999));
   endtask

   // field limits, including saturation toward both ends
   task automatic test_field_extremes();
      send_rotation(make_item(ROTOR_MAX, ROTOR_MAX, ROTOR_MAX, ROTOR_MAX,
                              POINT_MAX, POINT_MAX, POINT_MAX));
      send_rotation(make_item(ROTOR_MIN, ROTOR_MIN, ROTOR_MIN, ROTOR_MIN,
                              POINT_MIN, POINT_MIN, POINT_MIN));
      send_rotation(make_item(ROTOR_MAX, 0, 0, 0, POINT_MAX, 0, 0));
      send_rotation(make_item(ROTOR_MAX, 0, 0, 0, POINT_MIN, 0, 0));
      send_rotation(make_item(ROTOR_MIN, 0, 0, 0, 0, POINT_MAX, POINT_MIN));
      send_rotation(make_item(0, ROTOR_MIN, 0, 0, POINT_MAX, POINT_MIN, POINT_MAX));
      send_rotation(make_item(0, 0, 0, 0, POINT_MAX, POINT_MIN, POINT_MAX));
      send_rotation(make_item(ROTOR_MAX, ROTOR_MIN, ROTOR_MAX, ROTOR_MIN, -1, -1, -1));
   endtask

   // exact halves at each rescale round toward plus infinity
   task automatic test_rounding_ties();
      send_rotation(make_item(0, 1, 0, 0, 0, 32768, 0));
      send_rotation(make_item(0, 1, 0, 0, 0, -32768, 0));
      send_rotation(make_item(182, 0, 0, 0, 3, -3, 1));
      send_rotation(make_item(1, 1, 1, 1, 32768, 32767, -32768));
   endtask

   task automatic test_random_rotations(input int count);
      repeat (count) send_rotation(random_rotation());
   endtask

   // bursts, each followed by a full drain of the pipeline
   task automatic test_drain_between_bursts(input int bursts);
      repeat (bursts) begin
         repeat ($urandom_range(5, 35)) send_rotation(random_rotation());
         drop_request();
         wait_drained();
      end
   endtask

   // back-to-back transactions with no idling on either side
   task automatic test_steady_stream(input int count);
      steady_flow = 1'b1;
      repeat (count) send_rotation(random_rotation());
      drop_request();
      wait_drained();
      steady_flow = 1'b0;
   endtask

   // hard stop if the pipeline hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_points.size());
      $display("simulation failed");
      $finish;
   end

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.rotor_scalar = '0;
      req_ch.rotor_e12    = '0;
      req_ch.rotor_e23    = '0;
      req_ch.rotor_e31    = '0;
      req_ch.point_x      = '0;
      req_ch.point_y      = '0;
      req_ch.point_z      = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_identity_rotor();
      test_axis_turns();
      test_field_extremes();
      test_rounding_ties();
      test_random_rotations(400);
      test_drain_between_bursts(5);
      test_steady_stream(150);

      // let any stray response show up before judging
      drop_request();
      wait_drained();
      repeat (10) @(posedge clock);

      $display("checked %0d of %0d rotations (%0d saturated), directed limits and ties,",
               checked_count, sent_count, overflow_count);
      $display("random rotors under random stalls, full drains and a steady stream");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[filelist.f]
src/rvr_pkg.sv
src/rvr_req_if.sv
src/rvr_rsp_if.sv
src/rvr_cross.sv
src/rvr_sandwich.sv
src/rvr_saturate.sv
src/rotate_vector_by_rotor_unit.sv
sim/rotate_vector_by_rotor_unit_tb.sv
